// ===== design/csms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csms_pkg
// Shared types and constants of the current sensor median scaler.
// ----------------------------------------------------------------------------
package csms_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int GAIN_W       = 16;
  localparam int CURRENT_W    = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int WINDOW_SIZE_DEF = 5;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 10'd505;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd0;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GAIN   = 2'd1;

  // floor(s / 5) = (s * 3277) >> 14 for every 10-bit s
  localparam int                 ROUND_PROD_W = 22;
  localparam int                 ROUND_SHIFT  = 14;
  localparam logic [11:0]        ROUND_RECIP  = 12'd3277;

  // floor(m / 1000) = (m * ceil(2^40 / 1000)) >> 40 for m < 2^26
  localparam int                 MAG_W        = 26;
  localparam int                 RECIP_W      = 31;
  localparam int                 RECIP_SHIFT  = 40;
  localparam logic [RECIP_W-1:0] RECIP_K      = 31'd1099511628;

  localparam logic [CURRENT_W-1:0] CURRENT_MAX = 16'd33521;
  localparam logic [SAMPLE_W-1:0]  ROUNDED_MAX = 10'd1020;

  typedef struct packed {
    logic [SAMPLE_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;
  } cfg_t;

  typedef struct packed {
    logic                push;
    logic [SAMPLE_W-1:0] value;
  } push_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] value;
  } q_status_t;

endpackage

`default_nettype wire

// ===== design/current_sensor_median_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// current_sensor_median_scaler
// Rounds converter samples to a multiple of five, keeps a running-median
// window and scales the sample and the median to centiamps.
//
//   channel   handshake                  payload
//   sample    sample_valid/sample_stall  sample
//   result    result_valid/result_stall  rounded_sample, current_centiamp,
//                                        median_centiamp
//   config    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// In the back end an item takes one rank step per filled window entry,
// then two passes through the shared multiply and reciprocal unit. A
// two-entry queue lets the front accept samples while the back works.
// Reset is synchronous and clears the window fill state; window
// contents need no reset.
// ----------------------------------------------------------------------------
module current_sensor_median_scaler
  import csms_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic [SAMPLE_W-1:0]    sample,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [SAMPLE_W-1:0]         rounded_sample,
  output logic [CURRENT_W-1:0]        current_centiamp,
  output logic [CURRENT_W-1:0]        median_centiamp,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(WINDOW_SIZE + 1);

  cfg_t      cfg;
  push_t     push;
  q_status_t head;
  logic      queue_full;
  logic      pop;
  logic      busy;
  logic [CW-1:0] fill_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset <= OFFSET_RESET;
      cfg.gain   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_OFFSET: cfg.offset <= cfg_data[SAMPLE_W-1:0];
        CFG_IDX_GAIN:   cfg.gain   <= cfg_data[GAIN_W-1:0];
        default:        cfg        <= cfg;
      endcase
    end
  end

  csms_front u_front (
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .queue_full   (queue_full),
    .push         (push)
  );

  csms_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  csms_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .cfg              (cfg),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .rounded_sample   (rounded_sample),
    .current_centiamp (current_centiamp),
    .median_centiamp  (median_centiamp),
    .busy             (busy),
    .fill_level       (fill_level)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= CW'(WINDOW_SIZE))
    else $error("window fill exceeds window size");

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy))
    else $error("result raised without an item in flight");

  a_current_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (current_centiamp <= CURRENT_MAX) && (median_centiamp <= CURRENT_MAX))
    else $error("current out of range");

  a_rounded_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (rounded_sample <= ROUNDED_MAX))
    else $error("rounded sample out of range");

endmodule

`default_nettype wire

// ===== design/csms_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csms_front
// Accepts raw samples, rounds them down to a multiple of five and pushes
// them into the item queue.
// ----------------------------------------------------------------------------
module csms_front
  import csms_pkg::*;
(
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                queue_full,
  output push_t                    push
);

  logic [ROUND_PROD_W-1:0] round_prod;
  logic [7:0]              quot;

  assign round_prod   = ROUND_PROD_W'(sample) * ROUND_PROD_W'(ROUND_RECIP);
  assign quot         = round_prod[ROUND_PROD_W-1:ROUND_SHIFT];
  assign sample_stall = queue_full;
  assign push.push    = sample_valid & ~queue_full;
  assign push.value   = {quot, 2'b00} + SAMPLE_W'(quot);

endmodule

`default_nettype wire

// ===== design/csms_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csms_queue
// Short FIFO of rounded samples between the front and the back.
// ----------------------------------------------------------------------------
module csms_queue
  import csms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output logic       full,
  output q_status_t  head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SAMPLE_W-1:0] entry [QUEUE_DEPTH];
  logic [PW-1:0]       wptr;
  logic [PW-1:0]       rptr;
  logic [CW-1:0]       count;
  logic                do_pop;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.value = entry[rptr];
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (push.push) begin
      entry[wptr] <= push.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/csms_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csms_back
// Running-median window with rank counting over cycles, shared scaling
// unit (multiply, reciprocal divide by 1000) and output register.
// ----------------------------------------------------------------------------
module csms_back
  import csms_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire q_status_t            head,
  output logic                      pop,
  input  wire cfg_t                 cfg,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [SAMPLE_W-1:0]       rounded_sample,
  output logic [CURRENT_W-1:0]      current_centiamp,
  output logic [CURRENT_W-1:0]      median_centiamp,
  output logic                      busy,
  output logic [$clog2(WINDOW_SIZE+1)-1:0] fill_level
);

  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam int PRODW = MAG_W + RECIP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RANK  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_RECIP = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]           state;
  logic [SAMPLE_W-1:0]  window [WINDOW_SIZE];
  logic [CW-1:0]        rank   [WINDOW_SIZE];
  logic [CW-1:0]        fill;
  logic [IW-1:0]        slot;
  logic [IW-1:0]        scan;
  logic [SAMPLE_W-1:0]  cur_sample;
  logic [SAMPLE_W-1:0]  median;
  logic                 phase;
  logic [MAG_W-1:0]     mag;
  logic [CURRENT_W-1:0] cur_amp;
  logic [CURRENT_W-1:0] med_amp;

  logic [SAMPLE_W-1:0]        bcast;
  logic                       last_scan;
  logic [CW-1:0]              lo_rank;
  logic [CW-1:0]              hi_rank;
  logic [SAMPLE_W-1:0]        lo_val;
  logic [SAMPLE_W-1:0]        hi_val;
  logic [SAMPLE_W-1:0]        operand;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W+GAIN_W:0] prod_s;
  logic [MAG_W-1:0]           mag_next;
  logic [PRODW-1:0]           recip_prod;
  logic [CURRENT_W-1:0]       quot;
  logic                       out_free;

  assign busy       = (state != ST_IDLE);
  assign fill_level = fill;
  assign pop        = (state == ST_IDLE) & head.valid;
  assign bcast      = window[scan];
  assign last_scan  = (CW'(scan) == fill - 1'b1);
  assign lo_rank    = (fill - 1'b1) >> 1;
  assign hi_rank    = fill >> 1;
  assign out_free   = ~result_valid | ~result_stall;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (CW'(i) < fill) begin
        if (rank[i] == lo_rank) begin
          lo_val = lo_val | window[i];
        end
        if (rank[i] == hi_rank) begin
          hi_val = hi_val | window[i];
        end
      end
    end
  end

  assign operand    = phase ? median : cur_sample;
  assign diff       = $signed({1'b0, operand}) - $signed({1'b0, cfg.offset});
  assign prod_s     = diff * $signed(cfg.gain);
  assign mag_next   = prod_s[SAMPLE_W+GAIN_W] ? MAG_W'(-prod_s) : MAG_W'(prod_s);
  assign recip_prod = PRODW'(mag) * PRODW'(RECIP_K);
  assign quot       = recip_prod[RECIP_SHIFT+CURRENT_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (pop) begin
      window[slot] <= head.value;
      cur_sample   <= head.value;
    end
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (pop) begin
        rank[i] <= '0;
      end else if (state == ST_RANK) begin
        if ((bcast < window[i]) || ((bcast == window[i]) && (scan < IW'(i)))) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
    if (state == ST_PICK) begin
      median <= SAMPLE_W'(({1'b0, lo_val} + {1'b0, hi_val}) >> 1);
    end
    if (state == ST_MUL) begin
      mag <= mag_next;
    end
    if (state == ST_RECIP) begin
      if (phase) begin
        med_amp <= quot;
      end else begin
        cur_amp <= quot;
      end
    end
    if ((state == ST_OUT) && out_free) begin
      rounded_sample   <= cur_sample;
      current_centiamp <= cur_amp;
      median_centiamp  <= med_amp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      slot         <= '0;
      scan         <= '0;
      phase        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_OUT) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            slot  <= (slot == IW'(WINDOW_SIZE - 1)) ? '0 : slot + 1'b1;
            fill  <= (fill == CW'(WINDOW_SIZE)) ? fill : fill + 1'b1;
            scan  <= '0;
            state <= ST_RANK;
          end
        end
        ST_RANK: begin
          scan <= scan + 1'b1;
          if (last_scan) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          phase <= 1'b0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_RECIP;
        end
        ST_RECIP: begin
          if (phase) begin
            state <= ST_OUT;
          end else begin
            phase <= 1'b1;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
